### rtl/deque_with_search_macros.svh
// Assertion macros used by the deque top-level RTL file.
`ifndef DEQUE_WITH_SEARCH_MACROS_SVH
`define DEQUE_WITH_SEARCH_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define DQS_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("deque assertion failed");

// The condition must hold in the cycle after the trigger.
`define DQS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("deque assertion failed");

`endif

### rtl/dqs_pkg.sv
// Shared types and codes for the deque with search.
package dqs_pkg;

    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_LIST_FWD   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_LIST_BWD   = 3'd6;

    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] item;
        logic [COUNT_W-1:0]        count;
        logic                      last;
    } result_t;

endpackage

### rtl/deque_with_search.sv
// Top level of the bounded double-ended queue with search and listing.
//
// Commands arrive on the input channel (in_valid, in_stall, cmd, value) and
// results leave on the output channel (out_valid, out_stall, status, item,
// count, last). A transfer happens on a clock edge where valid is high and
// stall is low. Every command gives one result except a listing of a
// non-empty queue, which gives one result per entry with last set on the
// final one.
// Pushes, pops and unused codes appear at the output in the cycle after the
// input transfer, so they run at one per cycle while the receiver does not
// stall. A search reads the entry memory one entry per cycle and the status
// follows the last compare. A listing passes each entry through the memory
// read register and the output register and delivers one entry per cycle
// while the receiver does not stall; the memory read port sets that pace.
// Input is stalled for the whole walk.
// When the receiver stalls, the result stays in the output register and the
// block stops taking new commands or advancing a walk until it is taken.
// Reset empties the queue and clears the output valid flag; the entry memory
// needs no clearing pass.
`include "deque_with_search_macros.svh"

module deque_with_search import dqs_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [CMD_W-1:0]           cmd,
    input  logic signed [VALUE_W-1:0]  value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [STATUS_W-1:0]        status,
    output logic signed [VALUE_W-1:0]  item,
    output logic [COUNT_W-1:0]         count,
    output logic                       last
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_SRES = 2'd2;
    localparam logic [1:0] S_LIST = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [IW-1:0]      head_reg, head_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [IW-1:0]      ptr_reg, ptr_next;
    logic [CW-1:0]      rem_reg, rem_next;
    logic               dir_reg, dir_next;
    logic               hit_reg, hit_next;
    logic [VALUE_W-1:0] key_reg, key_next;

    logic               in_acc;
    logic               push_cmd;
    logic               full;
    logic               empty;
    logic [IW-1:0]      tail;
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic               ram_re;
    logic [IW-1:0]      ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;
    logic               ob_load;
    logic               ob_free;
    result_t            res;
    result_t            ob_dout;

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] p);
        return (p == IW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] p);
        return (p == '0) ? IW'(DEPTH - 1) : p - 1'b1;
    endfunction

    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] h,
                                               input logic [CW-1:0] off);
        logic [IW:0] s;
        s = {1'b0, h} + (IW+1)'(off);
        if (s >= (IW+1)'(DEPTH))
        begin
            s = s - (IW+1)'(DEPTH);
        end
        return s[IW-1:0];
    endfunction

    assign full     = (cnt_reg == CW'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign tail     = slot_of(head_reg, cnt_reg - 1'b1);
    assign in_stall = (state_reg != S_IDLE) || !ob_free;
    assign in_acc   = in_valid && !in_stall;
    assign push_cmd = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_BACK);

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        cnt_next   = cnt_reg;
        ptr_next   = ptr_reg;
        rem_next   = rem_reg;
        dir_next   = dir_reg;
        hit_next   = hit_reg;
        key_next   = key_reg;
        ram_we     = 1'b0;
        ram_waddr  = slot_of(head_reg, cnt_reg);
        ram_re     = 1'b0;
        ram_raddr  = ptr_reg;
        ob_load    = 1'b0;
        res        = '0;
        res.status = ST_DONE;
        res.last   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    ob_load = 1'b1;
                    unique case (cmd) inside
                        CMD_PUSH_FRONT, CMD_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                ram_we   = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                                if (cmd == CMD_PUSH_FRONT)
                                begin
                                    head_next = idx_dec(head_reg);
                                    ram_waddr = idx_dec(head_reg);
                                end
                            end
                        end
                        CMD_POP_BACK, CMD_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                cnt_next = cnt_reg - 1'b1;
                                if (cmd == CMD_POP_FRONT)
                                begin
                                    head_next = idx_inc(head_reg);
                                end
                            end
                        end
                        CMD_SEARCH:
                        begin
                            if (empty)
                            begin
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                ob_load    = 1'b0;
                                ram_re     = 1'b1;
                                ram_raddr  = head_reg;
                                ptr_next   = idx_inc(head_reg);
                                rem_next   = cnt_reg;
                                key_next   = value;
                                hit_next   = 1'b0;
                                state_next = S_SCAN;
                            end
                        end
                        CMD_LIST_FWD, CMD_LIST_BWD:
                        begin
                            if (empty)
                            begin
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                ob_load    = 1'b0;
                                ram_re     = 1'b1;
                                rem_next   = cnt_reg;
                                dir_next   = (cmd == CMD_LIST_BWD);
                                state_next = S_LIST;
                                if (cmd == CMD_LIST_BWD)
                                begin
                                    ram_raddr = tail;
                                    ptr_next  = idx_dec(tail);
                                end
                                else
                                begin
                                    ram_raddr = head_reg;
                                    ptr_next  = idx_inc(head_reg);
                                end
                            end
                        end
                        default:
                        begin
                            res.status = ST_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                hit_next = hit_reg || (ram_rdata == key_reg);
                rem_next = rem_reg - 1'b1;
                if (rem_reg == CW'(1))
                begin
                    state_next = S_SRES;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_reg;
                    ptr_next  = idx_inc(ptr_reg);
                end
            end
            S_SRES:
            begin
                if (ob_free)
                begin
                    ob_load    = 1'b1;
                    res.status = hit_reg ? ST_FOUND : ST_NOTFOUND;
                    state_next = S_IDLE;
                end
            end
            S_LIST:
            begin
                if (ob_free)
                begin
                    ob_load  = 1'b1;
                    res.item = signed'(ram_rdata);
                    res.last = (rem_reg == CW'(1));
                    rem_next = rem_reg - 1'b1;
                    if (rem_reg == CW'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = ptr_reg;
                        ptr_next  = dir_reg ? idx_dec(ptr_reg) : idx_inc(ptr_reg);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res.count = COUNT_W'(cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            cnt_reg   <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        dir_reg <= dir_next;
        hit_reg <= hit_next;
        key_reg <= key_next;
    end

    dqs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dqs_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (ob_load),
        .din       (res),
        .free      (ob_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dout      (ob_dout)
    );

    assign status = ob_dout.status;
    assign item   = ob_dout.item;
    assign count  = ob_dout.count;
    assign last   = ob_dout.last;

    `DQS_ASSERT_IMPL(a_count_bound, 1'b1, cnt_reg <= CW'(DEPTH))
    `DQS_ASSERT_NEXT(a_push_grows, in_acc && !full && push_cmd, cnt_reg == CW'($past(cnt_reg) + 1'b1))
    `DQS_ASSERT_IMPL(a_walk_rem, state_reg == S_SCAN || state_reg == S_LIST, rem_reg != '0)
    `DQS_ASSERT_IMPL(a_load_free, ob_load, ob_free)

endmodule

### rtl/dqs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/dqs_obuf.sv
// Output register that holds one result until the receiver takes it.
module dqs_obuf import dqs_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t din,
    output logic    free,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t dout
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= din;
        end
    end

    assign out_valid = valid_reg;
    assign dout      = data_reg;

endmodule

### tb/tb_deque_with_search.sv
// Self-checking testbench for the bounded deque with search and listing.
`timescale 1ns / 1ps

module tb_deque_with_search import dqs_pkg::*;;

    localparam int DEPTH = 64;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    class deque_mirror;
        int                 depth;
        logic [VALUE_W-1:0] store [DEPTH];
        int                 head;
        int                 held;
        result_t            awaited [$];
        int                 errors;
        int                 commands;
        int                 results;
        int                 refused;
        int                 hits;
        int                 deepest;

        function new(int depth_i);
            depth = depth_i;
            head = 0;
            held = 0;
            errors = 0;
            commands = 0;
            results = 0;
            refused = 0;
            hits = 0;
            deepest = 0;
        endfunction

        function void await_result(logic [STATUS_W-1:0] st, logic [VALUE_W-1:0] it,
                                   logic fin);
            result_t r;
            r.status = st;
            r.item = it;
            r.count = held[COUNT_W-1:0];
            r.last = fin;
            awaited.push_back(r);
        endfunction

        function void note_command(logic [CMD_W-1:0] c, logic [VALUE_W-1:0] v);
            bit hit;
            int off;
            commands++;
            case (c) inside
                CMD_PUSH_FRONT, CMD_PUSH_BACK:
                begin
                    if (held >= depth)
                    begin
                        refused++;
                        await_result(ST_FULL, '0, 1'b1);
                    end
                    else
                    begin
                        if (c == CMD_PUSH_FRONT)
                        begin
                            head = (head + depth - 1) % depth;
                            store[head] = v;
                        end
                        else
                        begin
                            store[(head + held) % depth] = v;
                        end
                        held++;
                        if (held > deepest)
                        begin
                            deepest = held;
                        end
                        await_result(ST_DONE, '0, 1'b1);
                    end
                end
                CMD_POP_BACK, CMD_POP_FRONT:
                begin
                    if (held == 0)
                    begin
                        await_result(ST_EMPTY, '0, 1'b1);
                    end
                    else
                    begin
                        if (c == CMD_POP_FRONT)
                        begin
                            head = (head + 1) % depth;
                        end
                        held--;
                        await_result(ST_DONE, '0, 1'b1);
                    end
                end
                CMD_SEARCH:
                begin
                    if (held == 0)
                    begin
                        await_result(ST_EMPTY, '0, 1'b1);
                    end
                    else
                    begin
                        hit = 1'b0;
                        for (int i = 0; i < held; i++)
                        begin
                            if (store[(head + i) % depth] == v)
                            begin
                                hit = 1'b1;
                            end
                        end
                        if (hit)
                        begin
                            hits++;
                        end
                        await_result(hit ? ST_FOUND : ST_NOTFOUND, '0, 1'b1);
                    end
                end
                CMD_LIST_FWD, CMD_LIST_BWD:
                begin
                    if (held == 0)
                    begin
                        await_result(ST_EMPTY, '0, 1'b1);
                    end
                    else
                    begin
                        for (int i = 0; i < held; i++)
                        begin
                            off = (c == CMD_LIST_FWD) ? i : (held - 1 - i);
                            await_result(ST_DONE, store[(head + off) % depth],
                                         i == held - 1);
                        end
                    end
                end
                default:
                begin
                    await_result(ST_DONE, '0, 1'b1);
                end
            endcase
        endfunction

        function void check_result(result_t got);
            result_t want;
            results++;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing awaited, actual status %0d item %08h",
                         $time, got.status, got.item);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status)
            begin
                errors++;
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, got.status);
            end
            if (got.item !== want.item)
            begin
                errors++;
                $display("%0t: item mismatch, expected %08h, actual %08h",
                         $time, want.item, got.item);
            end
            if (got.count !== want.count)
            begin
                errors++;
                $display("%0t: count mismatch, expected %0d, actual %0d",
                         $time, want.count, got.count);
            end
            if (got.last !== want.last)
            begin
                errors++;
                $display("%0t: last mismatch, expected %0d, actual %0d",
                         $time, want.last, got.last);
            end
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [CMD_W-1:0]          cmd = '0;
    logic signed [VALUE_W-1:0] value = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] item;
    logic [COUNT_W-1:0]        count;
    logic                      last;

    deque_mirror        mirror;
    int                 tx_max = 5;
    int                 rx_max = 5;
    int                 out_wait = 0;
    int                 level = 0;
    logic [VALUE_W-1:0] pushed_vals [$];

    deque_with_search #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .item(item),
        .count(count),
        .last(last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            mirror.note_command(cmd, value);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            mirror.check_result({status, item, count, last});
        end
    end

    always @(posedge clk)
    begin
        int w;
        if (out_valid && !out_stall)
        begin
            w = $urandom_range(0, rx_max);
            out_wait = (w > 0) ? w - 1 : 0;
            out_stall <= (w > 0);
        end
        else if (out_wait > 0)
        begin
            out_wait = out_wait - 1;
        end
        else if (out_valid)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= (rx_max > 0) && ($urandom_range(0, 3) == 0);
        end
    end

    function automatic logic [VALUE_W-1:0] fresh_value();
        case ($urandom_range(0, 7)) inside
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4, 5: return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    task automatic send(input logic [CMD_W-1:0] c, input logic [VALUE_W-1:0] v);
        int gap;
        gap = $urandom_range(0, tx_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        value <= v;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        if ((c == CMD_PUSH_FRONT || c == CMD_PUSH_BACK) && level < DEPTH)
        begin
            level++;
            pushed_vals.push_back(v);
            if (pushed_vals.size() > 16)
            begin
                void'(pushed_vals.pop_front());
            end
        end
        else if ((c == CMD_POP_FRONT || c == CMD_POP_BACK) && level > 0)
        begin
            level--;
        end
    endtask

    task automatic send_mix(input int w_push, input int w_pop, input int w_search,
                            input int w_list, input int w_noise);
        int r;
        logic [CMD_W-1:0] c;
        logic [VALUE_W-1:0] v;
        r = $urandom_range(0, w_push + w_pop + w_search + w_list + w_noise - 1);
        v = $urandom;
        if (r < w_push)
        begin
            c = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            v = fresh_value();
        end
        else if (r < w_push + w_pop)
        begin
            c = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
        end
        else if (r < w_push + w_pop + w_search)
        begin
            c = CMD_SEARCH;
            if (pushed_vals.size() > 0 && $urandom_range(0, 1))
            begin
                v = pushed_vals[$urandom_range(0, pushed_vals.size() - 1)];
            end
            else
            begin
                v = fresh_value();
            end
        end
        else if (r < w_push + w_pop + w_search + w_list)
        begin
            c = $urandom_range(0, 1) ? CMD_LIST_FWD : CMD_LIST_BWD;
        end
        else
        begin
            c = CMD_UNUSED;
        end
        send(c, v);
    endtask

    initial
    begin
        #5_000_000;
        $display("[deque_with_search] ERROR");
        $finish;
    end

    initial
    begin
        mirror = new(DEPTH);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Operations on an empty queue, then a few entries at the value extremes.
        send(CMD_LIST_FWD, 32'h0);
        send(CMD_LIST_BWD, 32'hFFFF_FFFF);
        send(CMD_POP_FRONT, 32'h0);
        send(CMD_POP_BACK, 32'h0);
        send(CMD_SEARCH, 32'h0);
        send(CMD_UNUSED, 32'hDEAD_BEEF);
        send(CMD_PUSH_FRONT, 32'h8000_0000);
        send(CMD_PUSH_BACK, 32'h7FFF_FFFF);
        send(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
        send(CMD_PUSH_BACK, 32'h0000_0000);
        send(CMD_PUSH_FRONT, 32'h5555_5555);
        send(CMD_PUSH_BACK, 32'hAAAA_AAAA);
        send(CMD_SEARCH, 32'h7FFF_FFFF);
        send(CMD_SEARCH, 32'h8000_0000);
        send(CMD_SEARCH, 32'h1234_5678);
        send(CMD_LIST_FWD, 32'h0);
        send(CMD_LIST_BWD, 32'h0);
        send(CMD_POP_FRONT, 32'h0);
        send(CMD_POP_BACK, 32'h0);
        send(CMD_UNUSED, 32'h0);
        send(CMD_LIST_FWD, 32'h0);
        send(CMD_POP_FRONT, 32'h0);
        send(CMD_POP_BACK, 32'h0);
        send(CMD_POP_FRONT, 32'h0);
        send(CMD_POP_FRONT, 32'h0);

        repeat (10) send_mix(40, 25, 15, 15, 5);

        // Fill the queue with no idling on either side, then push against a full store.
        tx_max = 0;
        rx_max = 0;
        while (level < DEPTH)
        begin
            send_mix(94, 2, 2, 1, 1);
        end
        repeat (8) send_mix(60, 10, 20, 10, 0);

        tx_max = 5;
        rx_max = 5;
        while (level > 0)
        begin
            send_mix(2, 90, 4, 3, 1);
        end
        tx_max = 2;
        rx_max = 2;
        repeat (5) send_mix(20, 20, 20, 20, 20);

        in_valid <= 1'b0;
        @(posedge clk);
        while (mirror.awaited.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DEPTH + 8) @(posedge clk);

        $display("Run covered %0d commands and %0d results, filling to %0d of %0d entries.",
                 mirror.commands, mirror.results, mirror.deepest, DEPTH);
        $display("Pushes refused when full: %0d; searches that found a match: %0d.",
                 mirror.refused, mirror.hits);
        if (mirror.errors == 0)
        begin
            $display("[deque_with_search] OK");
        end
        else
        begin
            $display("[deque_with_search] ERROR");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/dqs_pkg.sv
rtl/dqs_ram.sv
rtl/dqs_obuf.sv
rtl/deque_with_search.sv
tb/tb_deque_with_search.sv
